@@ design/lsb_first_bit_packer_macros.svh @@
// Assertion macros for the LSB-first bit packer.
// Included by the top level; defining ASSERT_OFF compiles the checks away.
`ifndef LSB_FIRST_BIT_PACKER_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define LBP_ASSERT_IMPLY(label, ck, rn, a, b) \
	label: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
		else $error("lbp implication check failed");
`define LBP_ASSERT_ALWAYS(label, ck, rn, c) \
	label: assert property (@(posedge ck) disable iff (!rn) (c)) \
		else $error("lbp invariant check failed");
`else
`define LBP_ASSERT_IMPLY(label, ck, rn, a, b)
`define LBP_ASSERT_ALWAYS(label, ck, rn, c)
`endif
`endif

@@ design/lbp_pkg.sv @@
// Shared constants and controller/datapath interface types for the bit packer.
// No dependencies.
`default_nettype none
package lbp_pkg;

	localparam int MAX_CHUNK_BITS_DEF = 64;
	localparam int LIMIT_W = 20;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd8192;

	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_BINT   = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;

	// Register index, taken from paddr[2].
	localparam logic REG_LIMIT = 1'b0;

	// Bounded-integer length search tries bit weights 32 down to 1.
	localparam logic [2:0] SRCH_TOP = 3'd5;

	typedef struct packed {
		logic       load;
		logic       srch;
		logic [2:0] step;
		logic       pack;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic rem_zero;
	} sts_t;

endpackage
`default_nettype wire

@@ design/lsb_first_bit_packer.sv @@
// Sequence: write bits is accepted, packed in chunks of up to a byte (up to nine chunks), then
// closed; a bounded integer first runs a length search and is then packed the same way.
// Items are taken one at a time: in_stall stays high until an item is through. The packer moves
// at most one byte per cycle, and only while the output register is free; output stalls hold it.
// Reset: arst_n clears the partial byte, bit count, flags and the limit register (8192).
`default_nettype none
`include "lsb_first_bit_packer_macros.svh"
module lsb_first_bit_packer #(
	parameter int MAX_CHUNK_BITS = lbp_pkg::MAX_CHUNK_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  func,
	input  wire  [63:0] data_value,
	input  wire  [6:0]  bit_count,
	input  wire  [31:0] max_value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last_of_run,
	output logic        bunch_end,
	output logic        fault_seen,
	output logic        limit_seen,
	output logic [31:0] total_bits
);

	lbp_pkg::cmd_t cmd;
	lbp_pkg::sts_t sts;

	logic [lbp_pkg::LIMIT_W-1:0] limit_q;
	logic                        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == lbp_pkg::REG_LIMIT);
	assign prdata  = reg_sel ? 32'(limit_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lbp_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			limit_q <= pwdata[lbp_pkg::LIMIT_W-1:0];
		end
	end

	lbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbp_datapath #(
		.MAX_CHUNK_BITS (MAX_CHUNK_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.data_value  (data_value),
		.bit_count   (bit_count),
		.max_value   (max_value),
		.limit       (limit_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.bunch_end   (bunch_end),
		.fault_seen  (fault_seen),
		.limit_seen  (limit_seen),
		.total_bits  (total_bits)
	);

	// A beat is produced only into a free output register.
	`LBP_ASSERT_IMPLY(a_pack_slot, clk, arst_n, cmd.pack, sts.slot_free)
	`LBP_ASSERT_IMPLY(a_fin_slot, clk, arst_n, cmd.fin, sts.slot_free)
	// The controller issues at most one datapath command per cycle.
	`LBP_ASSERT_ALWAYS(a_one_cmd, clk, arst_n, $onehot0({cmd.load, cmd.srch, cmd.pack, cmd.fin}))

endmodule
`default_nettype wire

@@ design/lbp_ctrl.sv @@
// Sequencer of the bit packer: accepts items and steps the datapath.
// Depends on lbp_pkg for the command and status types and function codes.
`default_nettype none
module lbp_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [1:0]        func,
	input  lbp_pkg::sts_t     sts,
	output lbp_pkg::cmd_t     cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_PACK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic [2:0] step_q;
	logic [2:0] step_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		step_nxt  = step_q;
		cmd       = '0;
		cmd.step  = step_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					step_nxt = lbp_pkg::SRCH_TOP;
					case (func)
						lbp_pkg::FUNC_WRITE:  state_nxt = S_PACK;
						lbp_pkg::FUNC_BINT:   state_nxt = S_SRCH;
						lbp_pkg::FUNC_FINISH: state_nxt = S_FIN;
						default:              state_nxt = S_IDLE;
					endcase
				end
			end
			S_SRCH: begin
				cmd.srch = 1'b1;
				if (step_q == 3'd0) begin
					state_nxt = S_PACK;
				end else begin
					step_nxt = step_q - 3'd1;
				end
			end
			S_PACK: begin
				if (sts.rem_zero) begin
					state_nxt = S_IDLE;
				end else if (sts.slot_free) begin
					cmd.pack = 1'b1;
				end
			end
			S_FIN: begin
				if (sts.slot_free) begin
					cmd.fin   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= 3'd0;
		end else begin
			state_q <= state_nxt;
			step_q  <= step_nxt;
		end
	end

endmodule
`default_nettype wire

@@ design/lbp_datapath.sv @@
// Datapath of the bit packer: bit store, length search, byte packing and output register.
// Depends on lbp_pkg for the command and status types and function codes.
`default_nettype none
module lbp_datapath #(
	parameter int MAX_CHUNK_BITS = lbp_pkg::MAX_CHUNK_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  lbp_pkg::cmd_t                cmd,
	output lbp_pkg::sts_t                sts,
	input  wire  [1:0]                   func,
	input  wire  [63:0]                  data_value,
	input  wire  [6:0]                   bit_count,
	input  wire  [31:0]                  max_value,
	input  wire  [lbp_pkg::LIMIT_W-1:0]  limit,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [7:0]                   out_byte,
	output logic                         byte_valid,
	output logic                         last_of_run,
	output logic                         bunch_end,
	output logic                         fault_seen,
	output logic                         limit_seen,
	output logic [31:0]                  total_bits
);

	localparam int SH_W = (MAX_CHUNK_BITS > 32) ? MAX_CHUNK_BITS : 32;
	localparam int RW = $clog2(SH_W + 1);
	localparam logic [6:0] MAX_CNT = 7'(MAX_CHUNK_BITS);

	logic [SH_W-1:0] sh_q;
	logic [RW-1:0]   rem_q;
	logic [31:0]     max_q;
	logic [5:0]      n_q;
	logic [7:0]      pb_q;
	logic [2:0]      pc_q;
	logic [31:0]     bw_q;
	logic            lim_q;
	logic            flt_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q;
	logic        last_q;
	logic        end_q;
	logic        fault_q;
	logic        limit_q;
	logic [31:0] total_q;

	// Item load: clamp the count or the bounded value.
	logic [31:0] v_raw;
	logic        clamp_v;
	logic [31:0] v_ld;
	logic        cnt_over;
	logic [6:0]  cnt_ld;

	assign v_raw    = data_value[31:0];
	assign clamp_v  = (max_value != 32'd0) && (v_raw >= max_value);
	assign v_ld     = clamp_v ? (max_value - 32'd1) : v_raw;
	assign cnt_over = bit_count > MAX_CNT;
	assign cnt_ld   = cnt_over ? MAX_CNT : bit_count;

	// Length search. Bit k is emitted while (v mod 2^k) + 2^k < max; that sum grows
	// with k, so the emitted length is found one binary digit per cycle.
	logic [5:0]  cand;
	logic        cand_ok;
	logic [4:0]  k;
	logic [31:0] low_m;
	logic [32:0] lhs;
	logic        hit;
	logic [5:0]  n_nxt;

	assign cand    = n_q | (6'd1 << cmd.step);
	assign cand_ok = !cand[5] || (cand == 6'd32);
	assign k       = 5'(cand - 6'd1);
	assign low_m   = (32'd1 << k) - 32'd1;
	assign lhs     = {1'b0, sh_q[31:0] & low_m} + (33'd1 << k);
	assign hit     = cand_ok && (lhs < {1'b0, max_q});
	assign n_nxt   = hit ? cand : n_q;

	// Packing: move as many bits as fit into the partial byte.
	logic [3:0]    avail;
	logic [3:0]    take;
	logic [7:0]    chunk;
	logic [7:0]    merged;
	logic [3:0]    pc_sum;
	logic [32:0]   bw_sum;
	logic [31:0]   bw_new;
	logic          lim_hit;
	logic [RW-1:0] rem_after;
	logic          emit;

	assign avail     = 4'd8 - {1'b0, pc_q};
	assign take      = (rem_q < RW'(avail)) ? 4'(rem_q) : avail;
	assign chunk     = sh_q[7:0] & 8'((9'd1 << take) - 9'd1);
	assign merged    = pb_q | 8'(16'(chunk) << pc_q);
	assign pc_sum    = {1'b0, pc_q} + take;
	assign bw_sum    = {1'b0, bw_q} + 33'(take);
	assign bw_new    = bw_sum[32] ? 32'hFFFF_FFFF : bw_sum[31:0];
	assign lim_hit   = !lim_q && (bw_new > 32'(limit));
	assign rem_after = rem_q - RW'(take);
	assign emit      = pc_sum[3];

	assign sts.slot_free = !out_valid_q || !out_stall;
	assign sts.rem_zero  = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			pb_q  <= 8'd0;
			pc_q  <= 3'd0;
			bw_q  <= 32'd0;
			lim_q <= 1'b0;
			flt_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				case (func)
					lbp_pkg::FUNC_WRITE: begin
						rem_q <= RW'(cnt_ld);
						if (cnt_over) begin
							flt_q <= 1'b1;
						end
					end
					lbp_pkg::FUNC_BINT: begin
						rem_q <= '0;
						if (clamp_v) begin
							flt_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.srch && (cmd.step == 3'd0)) begin
				rem_q <= RW'(n_nxt);
			end
			if (cmd.pack) begin
				rem_q <= rem_after;
				bw_q  <= bw_new;
				if (lim_hit) begin
					lim_q <= 1'b1;
					flt_q <= 1'b1;
				end
				if (emit) begin
					pb_q <= 8'd0;
					pc_q <= 3'd0;
				end else begin
					pb_q <= merged;
					pc_q <= 3'(pc_sum);
				end
			end
			if (cmd.fin) begin
				pb_q <= 8'd0;
				pc_q <= 3'd0;
				bw_q <= 32'd0;
			end
		end
	end

	// Bit store and search registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= 6'd0;
			if (func == lbp_pkg::FUNC_BINT) begin
				sh_q  <= SH_W'(v_ld);
				max_q <= max_value;
			end else begin
				sh_q <= SH_W'(data_value[MAX_CHUNK_BITS-1:0]);
			end
		end
		if (cmd.srch) begin
			n_q <= n_nxt;
		end
		if (cmd.pack) begin
			sh_q <= sh_q >> take;
		end
	end

	// Output register: holds one beat; while it is full and stalled, packing waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.pack && emit) || cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack && emit) begin
			out_byte_q   <= merged;
			byte_valid_q <= 1'b1;
			last_q       <= rem_after < RW'(8);
			end_q        <= 1'b0;
			fault_q      <= flt_q | lim_hit;
			limit_q      <= lim_q | lim_hit;
			total_q      <= bw_new;
		end else if (cmd.fin) begin
			out_byte_q   <= pb_q;
			byte_valid_q <= (pc_q != 3'd0);
			last_q       <= 1'b1;
			end_q        <= 1'b1;
			fault_q      <= flt_q;
			limit_q      <= lim_q;
			total_q      <= bw_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_valid  = byte_valid_q;
	assign last_of_run = last_q;
	assign bunch_end   = end_q;
	assign fault_seen  = fault_q;
	assign limit_seen  = limit_q;
	assign total_bits  = total_q;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for lsb_first_bit_packer: directed table, then random phases
// under several limit settings. Output beats are checked against an in-bench packing model.
// Depends on lbp_pkg and the RTL of lsb_first_bit_packer.
`timescale 1ns / 100ps
module tb;

	localparam logic [1:0] FUNC_WRITE = lbp_pkg::FUNC_WRITE;
	localparam logic [1:0] FUNC_BINT = lbp_pkg::FUNC_BINT;
	localparam logic [1:0] FUNC_FINISH = lbp_pkg::FUNC_FINISH;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_LIMIT = {lbp_pkg::REG_LIMIT, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam int CHUNK_MAX = lbp_pkg::MAX_CHUNK_BITS_DEF;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        last_of_run;
		logic        bunch_end;
		logic        fault_seen;
		logic        limit_seen;
		logic [31:0] total_bits;
	} beat_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] data;
		logic [6:0]  count;
		logic [31:0] maxv;
	} item_t;

	// One directed step; when typed is set the step yields exactly the one beat given here.
	typedef struct packed {
		item_t       it;
		logic        typed;
		logic [7:0]  t_byte;
		logic        t_valid;
		logic        t_end;
		logic [31:0] t_total;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [63:0] data_value = '0;
	logic [6:0]  bit_count = '0;
	logic [31:0] max_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last_of_run;
	logic        bunch_end;
	logic        fault_seen;
	logic        limit_seen;
	logic [31:0] total_bits;

	lsb_first_bit_packer uut (.*);

	// Packing model state.
	logic [7:0]  part_byte = '0;
	int          part_cnt = 0;
	logic [31:0] bit_total = '0;
	logic        limit_flag = 1'b0;
	logic        fault_flag = 1'b0;
	logic [19:0] limit_reg = lbp_pkg::LIMIT_RESET;
	int          item_nres;

	beat_t pending_bytes[$];
	int    errors = 0;
	int    idle_cycles = 0;
	bit    calm = 0;
	bit    long_hold = 0;

	step_t steps [0:21] = '{
		'{'{FUNC_FINISH, 64'h0, 7'd0, 32'd0}, 1'b1, 8'h00, 1'b0, 1'b1, 32'd0},
		'{'{FUNC_WRITE, 64'hA5, 7'd8, 32'd0}, 1'b1, 8'hA5, 1'b1, 1'b0, 32'd8},
		'{'{FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_WRITE, 64'hF, 7'd4, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_FINISH, 64'h0, 7'd0, 32'd0}, 1'b1, 8'h0F, 1'b1, 1'b1, 32'd12},
		'{'{FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_WRITE, 64'h0123_4567_89AB_CDEF, 7'd63, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_BINT, 64'h3, 7'd0, 32'd8}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_BINT, 64'hFFFF_FFFF_FFFF_FFFE, 7'd0, 32'hFFFF_FFFF},
			1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_BINT, 64'h1_0000_0007, 7'd0, 32'd100}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_BINT, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 32'hFFFF_FFFF},
			1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_FINISH, 64'h0, 7'd0, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		// From here on the count and value clamps raise the fault flag.
		'{'{FUNC_WRITE, 64'h5A5A_5A5A_5A5A_5A5A, 7'd127, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_WRITE, 64'h0F0F_0F0F_0F0F_0F0F, 7'd65, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_BINT, 64'd200, 7'd0, 32'd100}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_BINT, 64'd7, 7'd0, 32'd1}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_BINT, 64'hFFFF_FFFF, 7'd0, 32'hFFFF_FFFF}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_WRITE, 64'h1, 7'd1, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_FINISH, 64'h0, 7'd0, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_FINISH, 64'h0, 7'd0, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0},
		'{'{FUNC_UNUSED, 64'h0, 7'd0, 32'd0}, 1'b0, 8'h0, 1'b0, 1'b0, 32'd0}
	};

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void emit_byte(input logic [7:0] b, input logic v, input logic e);
		beat_t nb;
		if (item_nres < 8) begin
			nb = {b, v, 1'b0, e, fault_flag, limit_flag, bit_total};
			pending_bytes = {pending_bytes, nb};
			item_nres++;
		end
	endfunction

	function automatic void push_bit(input logic b);
		if (b)
			part_byte[3'(part_cnt)] = 1'b1;
		part_cnt++;
		if (bit_total != 32'hFFFF_FFFF)
			bit_total++;
		if (!limit_flag && bit_total > {12'd0, limit_reg}) begin
			limit_flag = 1'b1;
			fault_flag = 1'b1;
		end
		if (part_cnt == 8) begin
			emit_byte(part_byte, 1'b1, 1'b0);
			part_byte = '0;
			part_cnt = 0;
		end
	endfunction

	// Appends the beats one item produces to pending_bytes and updates the packing state.
	function automatic void pack_item(input item_t it);
		int n;
		int i;
		logic [31:0] v;
		longint unsigned run;
		longint unsigned mask;
		beat_t t;
		item_nres = 0;
		case (it.func)
			FUNC_WRITE: begin
				n = int'(it.count);
				if (n > CHUNK_MAX) begin
					n = CHUNK_MAX;
					fault_flag = 1'b1;
				end
				for (i = 0; i < n; i++)
					push_bit(it.data[6'(i)]);
			end
			FUNC_BINT: begin
				if (it.maxv != 0) begin
					v = it.data[31:0];
					if (v >= it.maxv) begin
						v = it.maxv - 32'd1;
						fault_flag = 1'b1;
					end
					run = 0;
					mask = 1;
					while (mask <= 64'h8000_0000 && run + mask < {32'd0, it.maxv}) begin
						push_bit(|(v & mask[31:0]));
						if ((v & mask[31:0]) != 0)
							run = run | mask;
						mask = mask << 1;
					end
				end
			end
			FUNC_FINISH: begin
				if (part_cnt != 0)
					emit_byte(part_byte, 1'b1, 1'b1);
				else
					emit_byte(8'h00, 1'b0, 1'b1);
				part_byte = '0;
				part_cnt = 0;
				bit_total = '0;
			end
			default: ;
		endcase
		if (item_nres > 0) begin
			t = pending_bytes[pending_bytes.size() - 1];
			t.last_of_run = 1'b1;
			pending_bytes[pending_bytes.size() - 1] = t;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int r;
		int pick;
		it.data = {$urandom, $urandom};
		it.count = 7'($urandom_range(0, 127));
		it.maxv = $urandom;
		r = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		if (r < 45) begin
			it.func = FUNC_WRITE;
			if (pick < 7)
				it.count = 7'($urandom_range(0, 64));
			else if (pick < 8)
				it.count = 7'd64;
		end else if (r < 80) begin
			it.func = FUNC_BINT;
			if (pick < 3)
				it.maxv = $urandom_range(1, 20);
			else if (pick < 6)
				it.maxv = $urandom_range(1, 65535);
			else if (pick < 7)
				it.maxv = 32'd0;
			// Most bounded values fall inside the bound; the rest are random and may get clamped.
			if (it.maxv != 0 && $urandom_range(0, 9) < 7)
				it.data[31:0] = $urandom % it.maxv;
		end else if (r < 93) begin
			it.func = FUNC_FINISH;
		end else begin
			it.func = FUNC_UNUSED;
		end
		return it;
	endfunction

	task automatic offer(input item_t it, input logic typed, input beat_t fixed);
		int gap;
		int mark;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		func <= it.func;
		data_value <= it.data;
		bit_count <= it.count;
		max_value <= it.maxv;
		in_valid <= 1'b1;
		mark = pending_bytes.size();
		pack_item(it);
		if (typed) begin
			while (pending_bytes.size() > mark)
				void'(pending_bytes.pop_back());
			pending_bytes = {pending_bytes, fixed};
		end
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic run_random(input int count);
		item_t it;
		int done;
		done = 0;
		while (done < count) begin
			it = rand_item();
			offer(it, 1'b0, '0);
			if (it.func != FUNC_UNUSED)
				done++;
		end
	endtask

	// Lets the block go idle: all beats in, plus time for an item that yields no beat.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr[2] == lbp_pkg::REG_LIMIT)
			limit_reg = value[19:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void report(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	// Receiver: random stalls, plus one long hold-off so the block backs up into its input.
	initial begin : rx_side
		bit held;
		int len;
		held = 0;
		forever begin
			@(negedge clk);
			if (long_hold && !held) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 25) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (len - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_beats
		beat_t got;
		beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_byte, byte_valid, last_of_run, bunch_end, fault_seen, limit_seen,
				total_bits};
			if (pending_bytes.size() == 0) begin
				report($sformatf("%0t: unexpected beat byte=%h total=%0d", $realtime,
					out_byte, total_bits));
			end else begin
				want = pending_bytes.pop_front();
				if (got !== want)
					report($sformatf({"%0t: beat mismatch byte %h/%h valid %b/%b last %b/%b ",
						"end %b/%b fault %b/%b limit %b/%b total %0d/%0d (exp/got)"},
						$realtime, want.out_byte, got.out_byte, want.byte_valid,
						got.byte_valid, want.last_of_run, got.last_of_run, want.bunch_end,
						got.bunch_end, want.fault_seen, got.fault_seen, want.limit_seen,
						got.limit_seen, want.total_bits, got.total_bits));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < $size(steps); k++)
			offer(steps[k].it, steps[k].typed, {steps[k].t_byte, steps[k].t_valid, 1'b1,
				steps[k].t_end, 1'b0, 1'b0, steps[k].t_total});
		drain();

		write_reg(ADDR_LIMIT, 32'hFFFF_FFFF);
		long_hold = 1;
		run_random(50);
		drain();

		write_reg(ADDR_LIMIT, ($urandom & 32'hFFF0_0000) | $urandom_range(100, 600));
		run_random(50);
		drain();

		// Limit of zero, with a stretch of back-to-back beats on both sides.
		write_reg(ADDR_LIMIT, 32'h0);
		calm = 1;
		run_random(25);
		calm = 0;
		run_random(25);
		drain();

		// A write to an unmapped address must leave the limit alone.
		write_reg(ADDR_UNUSED, $urandom);
		run_random(60);
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
